[src/rocf_pkg.sv]
package rocf_pkg;

  localparam int DistW   = 16;
  localparam int EnergyW = 8;
  localparam int InDataW = 56;
  localparam int OutDataW = 56;
  localparam int AddrW   = 4;

  // register byte addresses
  localparam logic [AddrW-1:0] AddrDistBand   = 4'h0;
  localparam logic [AddrW-1:0] AddrEnergyBand = 4'h4;
  localparam logic [AddrW-1:0] AddrPinMode    = 4'h8;

  typedef struct packed {
    logic               frame_valid;
    logic               still_present;
    logic               move_present;
    logic [DistW-1:0]   still_distance;
    logic [DistW-1:0]   move_distance;
    logic [EnergyW-1:0] still_energy;
    logic [EnergyW-1:0] move_energy;
  } frame_t;

  typedef struct packed {
    logic [1:0]         target_state;
    logic [DistW-1:0]   still_distance;
    logic [DistW-1:0]   move_distance;
    logic [EnergyW-1:0] still_energy;
    logic [EnergyW-1:0] move_energy;
    logic               still_presence_changed;
    logic               move_presence_changed;
    logic               still_distance_changed;
    logic               move_distance_changed;
    logic               still_energy_changed;
    logic               move_energy_changed;
  } result_t;

  typedef struct packed {
    logic [DistW-1:0]   distance_deadband;
    logic [EnergyW-1:0] energy_deadband;
    logic               pin_presence_mode;
  } cfg_t;

endpackage

[src/rocf_cfg.sv]
module rocf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rocf_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rocf_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr)
        rocf_pkg::AddrDistBand:   cfg.distance_deadband <= pwdata[rocf_pkg::DistW-1:0];
        rocf_pkg::AddrEnergyBand: cfg.energy_deadband   <= pwdata[rocf_pkg::EnergyW-1:0];
        rocf_pkg::AddrPinMode:    cfg.pin_presence_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      rocf_pkg::AddrDistBand:
        prdata = {{(32-rocf_pkg::DistW){1'b0}}, cfg.distance_deadband};
      rocf_pkg::AddrEnergyBand:
        prdata = {{(32-rocf_pkg::EnergyW){1'b0}}, cfg.energy_deadband};
      rocf_pkg::AddrPinMode:
        prdata = {31'd0, cfg.pin_presence_mode};
      default:
        prdata = 32'd0;
    endcase
  end

endmodule

[src/rocf_core.sv]
module rocf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  rocf_pkg::frame_t  frame,
  input  rocf_pkg::cfg_t    cfg,
  output rocf_pkg::result_t res,
  output logic              emit
);

  logic                          awaiting_first;
  logic [1:0]                    held_presence;
  logic [rocf_pkg::DistW-1:0]    held_still_distance;
  logic [rocf_pkg::DistW-1:0]    held_move_distance;
  logic [rocf_pkg::EnergyW-1:0]  held_still_energy;
  logic [rocf_pkg::EnergyW-1:0]  held_move_energy;

  logic [1:0]                    pres;
  logic [rocf_pkg::DistW-1:0]    sd_diff, md_diff;
  logic [rocf_pkg::EnergyW-1:0]  se_diff, me_diff;
  logic                          sd_over, md_over, se_over, me_over;
  logic                          c_sp, c_mp, c_sd, c_md, c_se, c_me;
  logic                          take;

  assign pres = {frame.move_present, frame.still_present};

  always_comb begin
    sd_diff = (held_still_distance > frame.still_distance) ?
              held_still_distance - frame.still_distance :
              frame.still_distance - held_still_distance;
    md_diff = (held_move_distance > frame.move_distance) ?
              held_move_distance - frame.move_distance :
              frame.move_distance - held_move_distance;
    se_diff = (held_still_energy > frame.still_energy) ?
              held_still_energy - frame.still_energy :
              frame.still_energy - held_still_energy;
    me_diff = (held_move_energy > frame.move_energy) ?
              held_move_energy - frame.move_energy :
              frame.move_energy - held_move_energy;
  end

  assign sd_over = sd_diff > cfg.distance_deadband;
  assign md_over = md_diff > cfg.distance_deadband;
  assign se_over = se_diff > cfg.energy_deadband;
  assign me_over = me_diff > cfg.energy_deadband;

  // first frame forces every flag, but pin mode keeps the presence flags clear
  assign c_sp = !cfg.pin_presence_mode && (awaiting_first || (held_presence[0] != pres[0]));
  assign c_mp = !cfg.pin_presence_mode && (awaiting_first || (held_presence[1] != pres[1]));
  assign c_sd = awaiting_first || sd_over;
  assign c_md = awaiting_first || md_over;
  assign c_se = awaiting_first || se_over;
  assign c_me = awaiting_first || me_over;

  assign emit = frame.frame_valid && (c_sp || c_mp || c_sd || c_md || c_se || c_me);
  assign take = adv && frame.frame_valid;

  always_comb begin
    res.target_state           = pres;
    res.still_distance         = frame.still_distance;
    res.move_distance          = frame.move_distance;
    res.still_energy           = frame.still_energy;
    res.move_energy            = frame.move_energy;
    res.still_presence_changed = c_sp;
    res.move_presence_changed  = c_mp;
    res.still_distance_changed = c_sd;
    res.move_distance_changed  = c_md;
    res.still_energy_changed   = c_se;
    res.move_energy_changed    = c_me;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first      <= 1'b1;
      held_presence       <= '0;
      held_still_distance <= '0;
      held_move_distance  <= '0;
      held_still_energy   <= '0;
      held_move_energy    <= '0;
    end else if (take) begin
      awaiting_first <= 1'b0;
      held_presence  <= pres;
      if (c_sd) held_still_distance <= frame.still_distance;
      if (c_md) held_move_distance  <= frame.move_distance;
      if (c_se) held_still_energy   <= frame.still_energy;
      if (c_me) held_move_energy    <= frame.move_energy;
    end
  end

endmodule

[src/presence_report_on_change_filter.sv]
// channel | dir | width                    | contents
// s_axis  | in  | tdata 56, tuser 1        | one presence frame per request
// m_axis  | out | tdata 56                 | one report per changed frame
// apb     | in  | paddr 4, data 32         | deadbands and pin mode
//
// one frame per cycle sustained while reports are not stalled; a report passes through
// the input register, then the result register
// held values update as a frame passes from the input register to the result register
// a stalled report holds the input register; frames without a report drain freely
// rst is synchronous and clears config, held values and both stages
module presence_report_on_change_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] still_present, [1] move_present, [17:2] still_distance,
  // [33:18] move_distance, [41:34] still_energy, [49:42] move_energy
  input  logic [55:0] s_axis_tdata,
  // [0] frame_valid
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] target_state, [17:2] out_still_distance, [33:18] out_move_distance,
  // [41:34] out_still_energy, [49:42] out_move_energy, [50] still_presence_changed,
  // [51] move_presence_changed, [52] still_distance_changed,
  // [53] move_distance_changed, [54] still_energy_changed, [55] move_energy_changed
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rocf_pkg::cfg_t    cfg;
  rocf_pkg::frame_t  in_frame;
  rocf_pkg::frame_t  s1_frame;
  logic              s1_valid;
  rocf_pkg::result_t res;
  rocf_pkg::result_t out_res;
  logic              out_valid;
  logic              emit;
  logic              adv;

  rocf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    in_frame.frame_valid    = s_axis_tuser;
    in_frame.still_present  = s_axis_tdata[0];
    in_frame.move_present   = s_axis_tdata[1];
    in_frame.still_distance = s_axis_tdata[17:2];
    in_frame.move_distance  = s_axis_tdata[33:18];
    in_frame.still_energy   = s_axis_tdata[41:34];
    in_frame.move_energy    = s_axis_tdata[49:42];
  end

  assign adv           = s1_valid && (!out_valid || m_axis_tready || !emit);
  assign s_axis_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_frame <= in_frame;
    end
  end

  rocf_core u_core (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .frame (s1_frame),
    .cfg   (cfg),
    .res   (res),
    .emit  (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.move_energy_changed, out_res.still_energy_changed,
                          out_res.move_distance_changed, out_res.still_distance_changed,
                          out_res.move_presence_changed, out_res.still_presence_changed,
                          out_res.move_energy, out_res.still_energy,
                          out_res.move_distance, out_res.still_distance,
                          out_res.target_state};

endmodule

[bench/presence_report_on_change_filter_tb.sv]
module presence_report_on_change_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongHold = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // copy of the filter state and its registers
  logic                         awaiting_first = 1'b1;
  logic [1:0]                   held_presence = '0;
  logic [rocf_pkg::DistW-1:0]   held_sd = '0;
  logic [rocf_pkg::DistW-1:0]   held_md = '0;
  logic [rocf_pkg::EnergyW-1:0] held_se = '0;
  logic [rocf_pkg::EnergyW-1:0] held_me = '0;
  logic [rocf_pkg::DistW-1:0]   dist_band = '0;
  logic [rocf_pkg::EnergyW-1:0] energy_band = '0;
  logic                         pin_mode = 1'b0;

  rocf_pkg::result_t pending_reports[$];
  int      fail_count = 0;
  bit      src_gaps = 1'b0;
  bit      sink_gaps = 1'b0;
  bit      long_hold = 1'b0;

  presence_report_on_change_filter dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("presence_report_on_change_filter_tb: FAIL");
    $finish;
  end

  function automatic bit beyond_band(int unsigned held, int unsigned now, int unsigned band);
    return ((held > now) ? held - now : now - held) > band;
  endfunction

  // updates the held values and queues the report the frame should produce
  task automatic track_frame(input rocf_pkg::frame_t f);
    rocf_pkg::result_t r;
    logic [1:0]        pres;
    pres = {f.move_present, f.still_present};
    if (!f.frame_valid) return;
    r.target_state   = pres;
    r.still_distance = f.still_distance;
    r.move_distance  = f.move_distance;
    r.still_energy   = f.still_energy;
    r.move_energy    = f.move_energy;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      held_sd = f.still_distance;
      held_md = f.move_distance;
      held_se = f.still_energy;
      held_me = f.move_energy;
      r.still_presence_changed = 1'b1;
      r.move_presence_changed  = 1'b1;
      r.still_distance_changed = 1'b1;
      r.move_distance_changed  = 1'b1;
      r.still_energy_changed   = 1'b1;
      r.move_energy_changed    = 1'b1;
    end else begin
      r.still_presence_changed = held_presence[0] ^ pres[0];
      r.move_presence_changed  = held_presence[1] ^ pres[1];
      r.still_distance_changed = beyond_band(32'(held_sd), 32'(f.still_distance),
                                             32'(dist_band));
      r.move_distance_changed  = beyond_band(32'(held_md), 32'(f.move_distance),
                                             32'(dist_band));
      r.still_energy_changed   = beyond_band(32'(held_se), 32'(f.still_energy),
                                             32'(energy_band));
      r.move_energy_changed    = beyond_band(32'(held_me), 32'(f.move_energy),
                                             32'(energy_band));
      if (r.still_distance_changed) held_sd = f.still_distance;
      if (r.move_distance_changed) held_md = f.move_distance;
      if (r.still_energy_changed) held_se = f.still_energy;
      if (r.move_energy_changed) held_me = f.move_energy;
    end
    held_presence = pres;
    if (pin_mode) begin
      r.still_presence_changed = 1'b0;
      r.move_presence_changed  = 1'b0;
    end
    if (r.still_presence_changed || r.move_presence_changed || r.still_distance_changed ||
        r.move_distance_changed || r.still_energy_changed || r.move_energy_changed)
      pending_reports.push_back(r);
  endtask

  function automatic rocf_pkg::frame_t mk_frame(bit v, bit sp, bit mp, int unsigned sd,
                                                int unsigned md, int unsigned se,
                                                int unsigned me);
    rocf_pkg::frame_t f;
    f.frame_valid    = v;
    f.still_present  = sp;
    f.move_present   = mp;
    f.still_distance = 16'(sd);
    f.move_distance  = 16'(md);
    f.still_energy   = 8'(se);
    f.move_energy    = 8'(me);
    return f;
  endfunction

  // offset that lands on both sides of the deadband edge
  function automatic int near_offset(int unsigned band);
    int mag;
    case ($urandom_range(0, 3))
      0:       mag = band;
      1:       mag = band + 1;
      default: mag = $urandom_range(0, band + 2);
    endcase
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  function automatic rocf_pkg::frame_t random_frame();
    rocf_pkg::frame_t f;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    f.frame_valid = (pick >= 8);
    if (pick < 40) begin
      f.still_present  = 1'($urandom);
      f.move_present   = 1'($urandom);
      f.still_distance = 16'($urandom);
      f.move_distance  = 16'($urandom);
      f.still_energy   = 8'($urandom);
      f.move_energy    = 8'($urandom);
    end else begin
      f.still_present  = held_presence[0] ^ ($urandom_range(0, 3) == 0);
      f.move_present   = held_presence[1] ^ ($urandom_range(0, 3) == 0);
      f.still_distance = 16'(held_sd + near_offset(32'(dist_band)));
      f.move_distance  = 16'(held_md + near_offset(32'(dist_band)));
      f.still_energy   = 8'(held_se + near_offset(32'(energy_band)));
      f.move_energy    = 8'(held_me + near_offset(32'(energy_band)));
    end
    return f;
  endfunction

  // entered and left at a rising edge
  task automatic offer_frame(input rocf_pkg::frame_t f);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f.frame_valid;
    s_axis_tdata  <= {6'b0, f.move_energy, f.still_energy, f.move_distance,
                      f.still_distance, f.move_present, f.still_present};
    do @(posedge clk); while (!s_axis_tready);
    track_frame(f);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // frames without a report may still sit in the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rocf_pkg::AddrW-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      rocf_pkg::AddrDistBand:   dist_band = value[rocf_pkg::DistW-1:0];
      rocf_pkg::AddrEnergyBand: energy_band = value[rocf_pkg::EnergyW-1:0];
      rocf_pkg::AddrPinMode:    pin_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned dband, input int unsigned eband, input bit pin);
    wait_idle();
    write_reg(rocf_pkg::AddrDistBand, dband);
    write_reg(rocf_pkg::AddrEnergyBand, eband);
    write_reg(rocf_pkg::AddrPinMode, {31'd0, pin});
  endtask

  task automatic test_directed();
    configure(0, 0, 1);
    offer_frame(mk_frame(0, 1, 1, 'hFFFF, 'hFFFF, 'hFF, 'hFF));
    // first frame under pin mode still reports through the value flags
    offer_frame(mk_frame(1, 1, 0, 'hFFFF, 0, 'hFF, 0));
    configure(0, 0, 0);
    offer_frame(mk_frame(1, 0, 1, 'hFFFF, 0, 'hFF, 0));
    offer_frame(mk_frame(1, 0, 1, 'hFFFF, 0, 'hFF, 0));
    offer_frame(mk_frame(0, 1, 0, 'h1234, 'h4321, 'h12, 'h34));
    offer_frame(mk_frame(1, 0, 1, 0, 0, 0, 0));
    offer_frame(mk_frame(1, 1, 1, 'hFFFF, 'hFFFF, 'hFF, 'hFF));
    configure(100, 10, 0);
    offer_frame(mk_frame(1, 1, 1, 'hFFFF - 100, 'hFFFF - 100, 'hFF - 10, 'hFF - 10));
    offer_frame(mk_frame(1, 1, 1, 'hFFFF - 101, 'hFFFF, 'hFF - 11, 'hFF));
    offer_frame(mk_frame(1, 1, 1, 'hFFFF, 'hFFFF - 101, 'hFF, 'hFF - 11));
    // deadband at maximum: no value difference can exceed it
    configure('hFFFF, 'hFF, 0);
    offer_frame(mk_frame(1, 1, 1, 0, 0, 0, 0));
    offer_frame(mk_frame(1, 0, 0, 0, 0, 0, 0));
    configure('hFFFF, 'hFF, 1);
    offer_frame(mk_frame(1, 1, 1, 0, 0, 0, 0));
    // presence followed the masked frame, so no change here
    configure(0, 0, 0);
    offer_frame(mk_frame(1, 1, 1, 32'(held_sd), 32'(held_md), 32'(held_se), 32'(held_me)));
    offer_frame(mk_frame(1, 1, 0, 32'(held_sd), 32'(held_md), 32'(held_se), 32'(held_me)));
  endtask

  task automatic test_deadband_sweep();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(0, 0, 0);
        1: configure('hFFFF, 'hFF, 0);
        2: configure($urandom_range(1, 50), $urandom_range(1, 20), 1);
        3: configure($urandom_range(0, 'hFFFF), $urandom_range(0, 'hFF), 0);
        4: configure(3, 2, 1);
        default: configure(300, 40, 1'($urandom_range(0, 1)));
      endcase
      repeat (110) offer_frame(random_frame());
    end
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    configure(0, 0, 0);
    long_hold = 1'b1;
    // every frame differs, so each one produces a report
    for (int i = 0; i < 24; i++)
      offer_frame(mk_frame(1, i[0], i[1], held_sd + 1, $urandom, $urandom, $urandom));
    wait_idle();
  endtask

  task automatic test_steady_stream();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    configure(50, 5, 0);
    repeat (60) offer_frame(random_frame());
  endtask

  initial begin : sink_drive
    @(posedge clk);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < LongHold; n++) @(posedge clk);
        long_hold = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    rocf_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("report with none expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("target_state", 32'(want.target_state), 32'(m_axis_tdata[1:0]));
        check_field("out_still_distance", 32'(want.still_distance),
                    32'(m_axis_tdata[17:2]));
        check_field("out_move_distance", 32'(want.move_distance),
                    32'(m_axis_tdata[33:18]));
        check_field("out_still_energy", 32'(want.still_energy),
                    32'(m_axis_tdata[41:34]));
        check_field("out_move_energy", 32'(want.move_energy),
                    32'(m_axis_tdata[49:42]));
        check_field("still_presence_changed", 32'(want.still_presence_changed),
                    32'(m_axis_tdata[50]));
        check_field("move_presence_changed", 32'(want.move_presence_changed),
                    32'(m_axis_tdata[51]));
        check_field("still_distance_changed", 32'(want.still_distance_changed),
                    32'(m_axis_tdata[52]));
        check_field("move_distance_changed", 32'(want.move_distance_changed),
                    32'(m_axis_tdata[53]));
        check_field("still_energy_changed", 32'(want.still_energy_changed),
                    32'(m_axis_tdata[54]));
        check_field("move_energy_changed", 32'(want.move_energy_changed),
                    32'(m_axis_tdata[55]));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_deadband_sweep();
    test_backpressure();
    test_steady_stream();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("presence_report_on_change_filter_tb: PASS");
    end else begin
      $display("presence_report_on_change_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rocf_pkg.sv
src/rocf_cfg.sv
src/rocf_core.sv
src/presence_report_on_change_filter.sv
bench/presence_report_on_change_filter_tb.sv
